FILE: rtl/ptip_pkg.sv
// package for the prefixed integer text parser
// character codes, phase/radix/status codes and the control state struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptip_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;

    // ascii codes used by the digit decoder
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    // parse phase
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ZERO  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    // radix select
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] radix;
        logic [1:0] status;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{phase: PH_START, radix: RX_DEC, status: ST_OK};

endpackage

`default_nettype wire

FILE: rtl/ptip_step.sv
// single-character update of the parser: prefix detection, digit decode,
// shift-add multiply-accumulate with saturation; purely combinational
// depends on ptip_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptip_step #(
    parameter int VALUE_BITS = ptip_pkg::VALUE_BITS_DEFAULT
) (
    input  wire ptip_pkg::ctrl_t  ctrl,
    input  wire [VALUE_BITS-1:0]  acc,
    input  wire [7:0]             char_code,
    output ptip_pkg::ctrl_t       ctrl_next,
    output logic [VALUE_BITS-1:0] acc_next,
    output logic [VALUE_BITS-1:0] res_value
);
    import ptip_pkg::*;

    localparam int PW = VALUE_BITS + 5;

    logic          is_zero_char;
    logic          is_x_char;
    logic          digit_ok;
    logic [3:0]    digit_val;
    logic [1:0]    radix_eff;
    logic          take;
    logic          bad_digit;
    logic [PW-1:0] acc_ext;
    logic [PW-1:0] prod;
    logic          ovf;

    assign is_zero_char = (char_code == CHAR_ZERO);
    assign is_x_char    = (char_code == CHAR_LOWER_X);

    always_comb
    begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            digit_ok  = 1'b1;
            digit_val = 4'(char_code - CHAR_ZERO);
        end
        else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_F)
        begin
            digit_ok  = 1'b1;
            digit_val = 4'(char_code - CHAR_UPPER_A + 8'd10);
        end
    end

    // first character always parses as decimal
    assign radix_eff = (ctrl.phase == PH_START) ? RX_DEC : ctrl.radix;

    // prefix characters are not digits
    assign take = !((ctrl.phase == PH_START) && is_zero_char)
               && !((ctrl.phase == PH_ZERO) && is_x_char);

    assign acc_ext = PW'(acc);

    always_comb
    begin
        bad_digit = !digit_ok;
        prod      = (acc_ext << 3) + (acc_ext << 1) + PW'(digit_val);
        unique case (radix_eff)
            RX_OCT:
            begin
                bad_digit = !digit_ok || digit_val[3];
                prod      = (acc_ext << 3) + PW'(digit_val);
            end
            RX_HEX:
            begin
                prod = (acc_ext << 4) + PW'(digit_val);
            end
            default:
            begin
                bad_digit = !digit_ok || (digit_val > 4'd9);
            end
        endcase
    end

    assign ovf = |prod[PW-1:VALUE_BITS];

    always_comb
    begin
        ctrl_next = ctrl;
        acc_next  = acc;

        unique case (ctrl.phase)
            PH_START:
            begin
                ctrl_next.phase = is_zero_char ? PH_ZERO : PH_BODY;
                ctrl_next.radix = is_zero_char ? RX_OCT : RX_DEC;
            end
            PH_ZERO:
            begin
                ctrl_next.phase = PH_BODY;
                if (is_x_char)
                begin
                    ctrl_next.radix = RX_HEX;
                end
            end
            default:
            begin
                ctrl_next.phase = PH_BODY;
            end
        endcase

        if (take)
        begin
            priority if (bad_digit)
            begin
                ctrl_next.status = ST_BAD;
            end
            else if (ctrl.status != ST_OK)
            begin
                acc_next = acc;
            end
            else if (ovf)
            begin
                acc_next         = '1;
                ctrl_next.status = ST_OVF;
            end
            else
            begin
                acc_next = prod[VALUE_BITS-1:0];
            end
        end
    end

    assign res_value = (ctrl_next.status == ST_BAD) ? '0 : acc_next;

endmodule

`default_nettype wire

FILE: rtl/prefixed_integer_text_parser_top.sv
// top level of the prefixed integer text parser: input register, parse state,
// result register and stream handshakes
// depends on ptip_pkg and ptip_step
`timescale 1ns / 1ps
`default_nettype none

// Parses an unsigned number sent as text, one ASCII character per transfer on
// the slave side, with tlast on the final character. "0x" selects hex (0-9,
// A-F), a leading '0' selects octal, anything else decimal. One result per
// string leaves on the master side: the value in tdata, the status (ok, bad
// digit, overflow saturated) in tuser. One character is taken every clock
// while s_tready is high. The tlast character is held in the input register,
// then loads the result register and raises m_tvalid, later if the previous
// result is still waiting in the result register. The rate is set by the
// combinational shift-add update in ptip_step, which sits between the input
// register and the parse state / result registers. The input side keeps
// flowing while a result waits, until a second tlast character must be held.
module prefixed_integer_text_parser_top #(
    parameter int VALUE_BITS = ptip_pkg::VALUE_BITS_DEFAULT,
    parameter int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [7:0]            s_tdata,   // [7:0] char_code
    input  wire                  s_tlast,   // last_char
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // [VALUE_BITS-1:0] value, rest zero
    output logic [1:0]           m_tuser    // [1:0] status
);
    import ptip_pkg::*;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;
    logic                  in_fire;

    ctrl_t                 ctrl_reg;
    ctrl_t                 ctrl_next;
    ctrl_t                 step_ctrl;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [VALUE_BITS-1:0] step_acc;
    logic [VALUE_BITS-1:0] step_value;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [1:0]            out_status_reg;

    // a last character only moves on when the result slot frees up
    assign in_fire  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_fire;

    ptip_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .ctrl      (ctrl_reg),
        .acc       (acc_reg),
        .char_code (in_char_reg),
        .ctrl_next (step_ctrl),
        .acc_next  (step_acc),
        .res_value (step_value)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_fire)
        begin
            in_valid_next = 1'b0;
        end

        ctrl_next = ctrl_reg;
        acc_next  = acc_reg;
        if (in_fire)
        begin
            ctrl_next = in_last_reg ? CTRL_RESET : step_ctrl;
            acc_next  = in_last_reg ? '0 : step_acc;
        end

        out_valid_next = out_valid_reg;
        if (in_fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            ctrl_reg      <= ctrl_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_fire && in_last_reg)
        begin
            out_value_reg  <= step_value;
            out_status_reg <= step_ctrl.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_value_reg);
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/ptip_checker.sv
// port-level checks for the prefixed integer text parser, bound to the top level
// depends on ptip_pkg and prefixed_integer_text_parser_top
`timescale 1ns / 1ps
`default_nettype none

module ptip_checker #(
    parameter int VALUE_BITS = ptip_pkg::VALUE_BITS_DEFAULT,
    parameter int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire                  s_tlast,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [OUT_DATA_W-1:0] m_tdata,
    input wire [1:0]            m_tuser
);
    import ptip_pkg::*;

    localparam logic [OUT_DATA_W-1:0] SAT_VALUE = OUT_DATA_W'({VALUE_BITS{1'b1}});

    // a pending result is held until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // a bad digit always reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_BAD) |-> (m_tdata == '0))
        else $error("bad digit result with non-zero value");

    // overflow reports the saturated value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_OVF) |-> (m_tdata == SAT_VALUE))
        else $error("overflow result not saturated");

    // a new result needs a last character taken earlier through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a preceding last character");

endmodule

bind prefixed_integer_text_parser_top ptip_checker #(
    .VALUE_BITS (VALUE_BITS),
    .OUT_DATA_W (OUT_DATA_W)
) u_ptip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: test/prefixed_integer_text_parser_top_test.sv
// testbench for prefixed_integer_text_parser_top: sends number text one character per
// transfer, predicts each string's value and status, checks them against the master side
// depends on ptip_pkg and the parser rtl
`timescale 1ns / 1ps

module prefixed_integer_text_parser_top_test;

    import ptip_pkg::*;

    localparam int VB     = VALUE_BITS_DEFAULT;
    localparam int OUT_W  = ((VB + 7) / 8) * 8;
    localparam int TARGET_CHARS = 1750;
    localparam logic [7:0] NOT_A_DIGIT = 8'hFF;

    typedef struct {
        logic [VB-1:0] value;
        logic [1:0]    status;
    } parse_result_t;

    class number_scoreboard;
        logic [1:0]      phase;
        logic [1:0]      radix;
        logic [1:0]      status;
        longint unsigned accum;
        parse_result_t   expected_values[$];
        int              errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase  = PH_START;
            radix  = RX_DEC;
            status = ST_OK;
            accum  = 0;
        endfunction

        function void take_digit(logic [7:0] c);
            longint unsigned base;
            longint unsigned d;
            longint unsigned top;
            top  = (64'd1 << VB) - 1;
            base = (radix == RX_OCT) ? 8 : (radix == RX_HEX) ? 16 : 10;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                d = 64'(c - CHAR_ZERO);
            else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                d = 64'(c - CHAR_UPPER_A + 8'd10);
            else
                d = 64'(NOT_A_DIGIT);
            if (d >= base)
                status = ST_BAD;
            else if (status == ST_OK)
            begin
                if (accum > (top - d) / base)
                begin
                    accum  = top;
                    status = ST_OVF;
                end
                else
                    accum = accum * base + d;
            end
        endfunction

        function void note_char(logic [7:0] c, bit last);
            parse_result_t r;
            if (phase == PH_START)
            begin
                if (c == CHAR_ZERO)
                begin
                    radix = RX_OCT;
                    phase = PH_ZERO;
                end
                else
                begin
                    radix = RX_DEC;
                    phase = PH_BODY;
                    take_digit(c);
                end
            end
            else if (phase == PH_ZERO)
            begin
                phase = PH_BODY;
                if (c == CHAR_LOWER_X)
                    radix = RX_HEX;
                else
                    take_digit(c);
            end
            else
                take_digit(c);
            if (last)
            begin
                r.value  = (status == ST_BAD) ? '0 : accum[VB-1:0];
                r.status = status;
                expected_values.push_back(r);
                restart();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] tdata, logic [1:0] tuser);
            parse_result_t   e;
            logic [OUT_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                report($sformatf("result %h status %0d with none expected", tdata, tuser));
                return;
            end
            e    = expected_values.pop_front();
            want = OUT_W'(e.value);
            if (tdata !== want)
                report($sformatf("value %h, expected %h", tdata, want));
            if (tuser !== e.status)
                report($sformatf("status %0d, expected %0d", tuser, e.status));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    number_scoreboard sb = new();
    logic [7:0]       text_q[$];
    bit               tx_no_gaps = 1'b0;
    bit               rx_no_stalls = 1'b0;
    int               chars_sent = 0;

    prefixed_integer_text_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("prefixed_integer_text_parser_top_test: FAIL");
        $finish;
    end

    task send_char(logic [7:0] c, bit last);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task send_text();
        tx_no_gaps = ($urandom_range(0, 3) == 0);
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // digits of v in the given base, upper-case letters, at least min_digits long
    function automatic void push_number(longint unsigned v, int base, int min_digits);
        logic [7:0] digits[$];
        longint unsigned d;
        while (v != 0 || digits.size() < min_digits)
        begin
            d = v % base;
            digits.push_front(8'(d < 10 ? CHAR_ZERO + d : CHAR_UPPER_A + d - 10));
            v = v / base;
        end
        foreach (digits[i])
            text_q.push_back(digits[i]);
    endfunction

    function automatic void make_random_text();
        longint unsigned top;
        longint unsigned v;
        int              kind;
        int              base_sel;
        int              pos;
        top  = (64'd1 << VB) - 1;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // noise: raw bytes, biased towards the characters the decoder cares about
            repeat ($urandom_range(1, 5))
            begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(CHAR_ZERO);
                    1: text_q.push_back(CHAR_LOWER_X);
                    2: text_q.push_back(8'("a" + $urandom_range(0, 5)));
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        base_sel = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 64'($urandom_range(0, 999));
            4, 5:       v = $urandom & top;
            6:          v = top;
            7:          v = top + 1 + $urandom_range(0, 100);
            8:          v = longint'($urandom) * (1 + $urandom_range(0, 1023));
            default:    v = 64'($urandom_range(0, 15));
        endcase
        if (base_sel == 0)
            push_number(v, 10, 1);
        else if (base_sel == 1)
        begin
            text_q.push_back(CHAR_ZERO);
            push_number(v, 8, $urandom_range(0, 3));
        end
        else
        begin
            text_q.push_back(CHAR_ZERO);
            text_q.push_back(CHAR_LOWER_X);
            push_number(v, 16, $urandom_range(0, 3));
        end
        if (kind == 1)
        begin
            // broken string: one character overwritten, or junk on the end
            if ($urandom_range(0, 1))
            begin
                pos = $urandom_range(0, text_q.size() - 1);
                text_q[pos] = 8'($urandom_range(0, 255));
            end
            else
                text_q.push_back($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 5))
                                                       : 8'($urandom_range(0, 255)));
        end
    endfunction

    // master side: random stall before each result, checked on transfer
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int stall;
            if ($urandom_range(0, 15) == 0)
                rx_no_stalls = !rx_no_stalls;
            stall = rx_no_stalls ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone zero, bare prefix, x out of place, lower-case hex, bad octal digit,
        // letter in decimal, hex overflow, a top-bit byte
        push_string("0");          send_text();
        push_string("0x");         send_text();
        push_string("1x");         send_text();
        push_string("0xa");        send_text();
        push_string("08");         send_text();
        push_string("9A");         send_text();
        push_string("0xFFFFFFFF"); send_text();
        text_q.push_back(8'hFF);   send_text();

        while (chars_sent < TARGET_CHARS)
        begin
            make_random_text();
            send_text();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.expected_values.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.expected_values.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_values.size()));

        if (sb.errors == 0)
            $display("prefixed_integer_text_parser_top_test: PASS");
        else
            $display("prefixed_integer_text_parser_top_test: FAIL");
        $finish;
    end

endmodule
